// ----- hdl/odo_pkg.sv -----
// Shared types, constants and tables for the differential-drive odometry block.
package odo_pkg;

  // Fraction bits of positions and velocities.
  localparam int ODO_FRAC_BITS = 16;
  localparam int ODO_CORDIC_STEPS = 16;

  // Port widths.
  localparam int ODO_IN_W = 88;
  localparam int ODO_OUT_W = 160;
  localparam int ODO_CFG_IW = 1;
  localparam int ODO_CFG_DW = 24;

  // Divider dividend and divisor widths, CORDIC vector width.
  localparam int ODO_NW = 90;
  localparam int ODO_DW = 68;
  localparam int ODO_ZW = 34;
  localparam int ODO_KW = 5;

  // Register indexes.
  localparam logic [ODO_CFG_IW-1:0] REG_TPM = 1'b0;
  localparam logic [ODO_CFG_IW-1:0] REG_SEP = 1'b1;

  localparam logic [19:0] ODO_TPM_RESET = 20'd10000;
  localparam logic [23:0] ODO_SEP_RESET = 24'd200000;

  // 10^6 * binary angle units per radian, 10^6 and 10^12.
  localparam logic [63:0] ODO_K_ANG = 64'd683565276000000;
  localparam logic [63:0] ODO_K_US = 64'd1000000;
  localparam logic [63:0] ODO_K_US2 = 64'd1000000000000;

  // CORDIC start vector, gain compensated, Q4.30.
  localparam logic signed [ODO_ZW-1:0] ODO_GAIN_Q30 = 34'sd652032874;

  // Arctangent of 2^-k in binary angle units.
  localparam logic [31:0] ODO_ATAN_BAM [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RESET_POSE, S_PRIME, S_CALC,
    S_MUL_DEN, S_MUL_ANG, S_DIV_ANG, S_LD_C, S_DIV_C, S_CORDIC,
    S_MUL_X, S_ADD_X, S_ADD_Y,
    S_MUL_VLN, S_MUL_VLD, S_DIV_VL, S_MUL_VAN, S_MUL_VAD, S_DIV_VA,
    S_COMMIT, S_DONE
  } state_t;

  // Operand pairs of the multiply-accumulate unit.
  typedef enum logic [2:0] {
    MS_DEN, MS_ANG, MS_VLN, MS_VLD, MS_VAN, MS_VAD
  } mac_sel_t;

  // Where a quotient goes.
  typedef enum logic [2:0] {
    CAP_NONE, CAP_ANG, CAP_C, CAP_VL, CAP_VA
  } cap_t;

  typedef struct packed {
    logic     load;
    logic     clr_pose;
    logic     prime;
    logic     calc;
    logic     mac_go;
    mac_sel_t mac_sel;
    logic     div_go;
    logic     ld_cdiv;
    cap_t     cap;
    logic     cor_go;
    logic     mul_x;
    logic     mul_y;
    logic     add_x;
    logic     add_y;
    logic     commit;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic primed;
    logic intv_zero;
    logic mac_last;
    logic div_done;
    logic cor_done;
  } status_t;

endpackage

// ----- hdl/odo_div.sv -----
// Restoring divider, one quotient bit per cycle, rounding half up.
module odo_div #(
  parameter int NW = odo_pkg::ODO_NW,
  parameter int DW = odo_pkg::ODO_DW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic          done,
  output logic [NW-1:0] q
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] num;
  logic [DW-1:0] rem;
  logic [DW-1:0] dd;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   r2;
  logic          fits;
  logic [DW:0]   r2_sub;

  // Partial remainder with the next dividend bit brought down.
  always_comb begin
    r2     = {rem, num[NW-1]};
    fits   = r2 >= {1'b0, dd};
    r2_sub = r2 - {1'b0, dd};
  end

  // Control: busy until every dividend bit is worked, done pulses once after.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out, quotient shifts in behind it.
  always_ff @(posedge clk) begin
    if (go) begin
      num <= n + NW'(d >> 1);
      rem <= '0;
      dd  <= d;
    end else if (busy) begin
      rem <= fits ? r2_sub[DW-1:0] : r2[DW-1:0];
      num <= {num[NW-2:0], fits};
    end
  end

  assign q = num;

endmodule

// ----- hdl/odo_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::ODO_CORDIC_STEPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic [31:0]                         ang,
  output logic                                done,
  output logic signed [odo_pkg::ODO_ZW-1:0]   cos_o,
  output logic signed [odo_pkg::ODO_ZW-1:0]   sin_o
);
  import odo_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  logic signed [ODO_ZW-1:0] x;
  logic signed [ODO_ZW-1:0] y;
  logic signed [ODO_ZW-1:0] z;
  logic                     flip;
  logic                     busy;
  logic [CW-1:0]            cnt;
  logic [ODO_KW-1:0]        k;
  logic signed [ODO_ZW-1:0] at;
  logic                     flip_in;
  logic [31:0]              ang_f;

  // Fold into the right half-plane; a half turn negates both results.
  always_comb begin
    flip_in = ang[31] ^ ang[30];
    ang_f   = {ang[31] ^ flip_in, ang[30:0]};
    k       = ODO_KW'(cnt);
    at      = signed'(ODO_ZW'(ODO_ATAN_BAM[k]));
  end

  // Iteration counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One micro-rotation per cycle, direction from the residual angle.
  always_ff @(posedge clk) begin
    if (go) begin
      x    <= ODO_GAIN_Q30;
      y    <= '0;
      z    <= ODO_ZW'(signed'(ang_f));
      flip <= flip_in;
    end else if (busy) begin
      if (!z[ODO_ZW-1]) begin
        x <= x - (y >>> k);
        y <= y + (x >>> k);
        z <= z - at;
      end else begin
        x <= x + (y >>> k);
        y <= y - (x >>> k);
        z <= z + at;
      end
    end
  end

  assign cos_o = flip ? -x : x;
  assign sin_o = flip ? -y : y;

endmodule

// ----- hdl/odo_dp.sv -----
// Datapath: pose state, multiply-accumulate unit, divider, CORDIC and output register.
module odo_dp #(
  parameter int CORDIC_STEPS = odo_pkg::ODO_CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [odo_pkg::ODO_CFG_IW-1:0]    cfg_index,
  input  logic [odo_pkg::ODO_CFG_DW-1:0]    cfg_data,
  input  logic                              s_tuser,
  input  logic [odo_pkg::ODO_IN_W-1:0]      s_tdata,
  input  odo_pkg::cmd_t                     cmd,
  output odo_pkg::status_t                  status,
  output logic [odo_pkg::ODO_OUT_W-1:0]     m_tdata,
  output logic                              m_tuser
);
  import odo_pkg::*;

  // Configuration and architectural state.
  logic [19:0] tpm;
  logic [23:0] sep;
  logic [31:0] last_left;
  logic [31:0] last_right;
  logic        primed;
  logic [31:0] x_acc;
  logic [31:0] y_acc;
  logic [31:0] theta_acc;
  logic [31:0] vel_lin;
  logic [31:0] vel_ang;
  logic        updated;

  // Request fields.
  logic        mode_r;
  logic [31:0] left_r;
  logic [31:0] right_r;
  logic [23:0] intv_r;

  // Per-request working values.
  logic        sneg;
  logic        dneg;
  logic [32:0] smag;
  logic [32:0] dmag;
  logic [19:0] tpm_e;
  logic [23:0] sep_e;
  logic [43:0] den_r;
  logic [ODO_NW-1:0] n_r;
  logic [ODO_DW-1:0] d_r;
  logic [31:0] dth;
  logic [31:0] hth;
  logic signed [33:0] dc;
  logic signed [67:0] prod;

  // Multiply-accumulate unit.
  logic [47:0] mac_a;
  logic [63:0] mac_b;
  logic [ODO_NW-1:0] mac_acc;
  logic [1:0]  mac_cnt;
  logic        mac_busy;
  mac_sel_t    mac_sel_r;
  logic [47:0] a_sel;
  logic [63:0] b_sel;
  logic [63:0] mac_p;
  logic [ODO_NW-1:0] mac_sum;
  logic        mac_last;

  // Delta arithmetic.
  logic [31:0] dl32;
  logic [31:0] dr32;
  logic signed [33:0] sum34;
  logic signed [33:0] diff34;

  // Divider and CORDIC ports.
  logic        div_done;
  logic [ODO_NW-1:0] div_q;
  logic        cor_done;
  logic signed [ODO_ZW-1:0] cor_cos;
  logic signed [ODO_ZW-1:0] cor_sin;
  logic [31:0] cor_ang;

  // Position rounding.
  logic signed [67:0] prnd;
  logic signed [37:0] pstep;
  logic signed [38:0] x_sum;
  logic signed [38:0] y_sum;
  logic [32:0] cmag;

  function automatic logic [31:0] sat_mag(input logic [ODO_NW-1:0] q, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (q <= ODO_NW'(33'h080000000)) ? 32'd0 - q[31:0] : 32'h80000000;
    end else begin
      r = (q <= ODO_NW'(32'h7FFFFFFF)) ? q[31:0] : 32'h7FFFFFFF;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_pos(input logic signed [38:0] v);
    logic [31:0] r;
    if (v > 39'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -39'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Wrapped tick deltas, their sum and difference.
  always_comb begin
    dl32   = left_r - last_left;
    dr32   = right_r - last_right;
    sum34  = 34'(signed'(dl32)) + 34'(signed'(dr32));
    diff34 = 34'(signed'(dr32)) - 34'(signed'(dl32));
  end

  // Operand selection for the multiply-accumulate unit.
  always_comb begin
    a_sel = '0;
    b_sel = '0;
    unique case (cmd.mac_sel)
      MS_DEN: begin
        a_sel = 48'(tpm_e);
        b_sel = 64'(sep_e);
      end
      MS_ANG: begin
        a_sel = 48'(dmag);
        b_sel = ODO_K_ANG;
      end
      MS_VLN: begin
        a_sel = 48'(smag);
        b_sel = ODO_K_US;
      end
      MS_VLD: begin
        a_sel = 48'({tpm_e, 1'b0});
        b_sel = 64'(intv_r);
      end
      MS_VAN: begin
        a_sel = 48'(dmag);
        b_sel = ODO_K_US2;
      end
      MS_VAD: begin
        a_sel = 48'(den_r);
        b_sel = 64'(intv_r);
      end
      default: begin
        a_sel = '0;
        b_sel = '0;
      end
    endcase
  end

  // One 16-bit digit of the multiplier per cycle, most significant first.
  always_comb begin
    mac_p    = mac_a * 64'(mac_b[63:48]);
    mac_sum  = {mac_acc[ODO_NW-17:0], 16'd0} + ODO_NW'(mac_p);
    mac_last = mac_busy && (mac_cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_busy <= 1'b0;
      mac_cnt  <= '0;
    end else if (cmd.mac_go) begin
      mac_busy <= 1'b1;
      mac_cnt  <= '0;
    end else if (mac_busy) begin
      mac_cnt <= mac_cnt + 1'b1;
      if (mac_last) begin
        mac_busy <= 1'b0;
      end
    end
  end

  // Clamped centre distance from the divider.
  always_comb begin
    cmag = (div_q > ODO_NW'(33'h100000000)) ? 33'h100000000 : div_q[32:0];
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= s_tuser;
      left_r  <= s_tdata[31:0];
      right_r <= s_tdata[63:32];
      intv_r  <= s_tdata[87:64];
    end
    if (cmd.calc) begin
      sneg  <= sum34[33];
      dneg  <= diff34[33];
      smag  <= sum34[33] ? 33'(-sum34) : 33'(sum34);
      dmag  <= diff34[33] ? 33'(-diff34) : 33'(diff34);
      tpm_e <= (tpm == '0) ? 20'd1 : tpm;
      sep_e <= (sep == '0) ? 24'd1 : sep;
    end
    if (cmd.mac_go) begin
      mac_a     <= a_sel;
      mac_b     <= b_sel;
      mac_acc   <= '0;
      mac_sel_r <= cmd.mac_sel;
    end else if (mac_busy) begin
      mac_acc <= mac_sum;
      mac_b   <= {mac_b[47:0], 16'd0};
    end
    // Finished product goes to its operand register.
    if (mac_last) begin
      unique case (mac_sel_r)
        MS_DEN: begin
          den_r <= mac_sum[43:0];
          d_r   <= ODO_DW'(mac_sum[43:0]);
        end
        MS_ANG: n_r <= mac_sum;
        MS_VLN, MS_VAN: n_r <= mac_sum << ODO_FRAC_BITS;
        MS_VLD, MS_VAD: d_r <= mac_sum[ODO_DW-1:0];
        default: n_r <= mac_sum;
      endcase
    end
    if (cmd.ld_cdiv) begin
      n_r <= ODO_NW'(smag) << ODO_FRAC_BITS;
      d_r <= ODO_DW'({tpm_e, 1'b0});
    end
    if (cmd.cap == CAP_ANG) begin
      dth <= dneg ? 32'd0 - div_q[31:0] : div_q[31:0];
      hth <= dneg ? 32'd0 - div_q[32:1] : div_q[32:1];
    end
    if (cmd.cap == CAP_C) begin
      dc <= sneg ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});
    end
    if (cmd.mul_x) begin
      prod <= dc * cor_cos;
    end else if (cmd.mul_y) begin
      prod <= dc * cor_sin;
    end
  end

  // Rounded position step, added to the accumulators with saturation.
  always_comb begin
    prnd  = prod + 68'sd536870912;
    pstep = 38'(prnd >>> 30);
    x_sum = 39'(signed'(x_acc)) + 39'(pstep);
    y_sum = 39'(signed'(y_acc)) + 39'(pstep);
  end

  // Configuration and pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm        <= ODO_TPM_RESET;
      sep        <= ODO_SEP_RESET;
      last_left  <= '0;
      last_right <= '0;
      primed     <= 1'b0;
      x_acc      <= '0;
      y_acc      <= '0;
      theta_acc  <= '0;
      vel_lin    <= '0;
      vel_ang    <= '0;
      updated    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TPM: tpm <= cfg_data[19:0];
          REG_SEP: sep <= cfg_data[23:0];
        endcase
      end
      if (cmd.clr_pose) begin
        x_acc     <= '0;
        y_acc     <= '0;
        theta_acc <= '0;
        vel_lin   <= '0;
        vel_ang   <= '0;
        primed    <= 1'b0;
        updated   <= 1'b0;
      end
      if (cmd.prime) begin
        last_left  <= left_r;
        last_right <= right_r;
        primed     <= 1'b1;
        updated    <= 1'b0;
      end
      if (cmd.calc) begin
        last_left  <= left_r;
        last_right <= right_r;
      end
      if (cmd.cap == CAP_VL) begin
        vel_lin <= sat_mag(div_q, sneg);
      end
      if (cmd.cap == CAP_VA) begin
        vel_ang <= sat_mag(div_q, dneg);
      end
      if (cmd.add_x) begin
        x_acc <= sat_pos(x_sum);
      end
      if (cmd.add_y) begin
        y_acc <= sat_pos(y_sum);
      end
      if (cmd.commit) begin
        theta_acc <= theta_acc + dth;
        updated   <= 1'b1;
        if (intv_r == '0) begin
          vel_lin <= '0;
          vel_ang <= '0;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {vel_ang, vel_lin, theta_acc, y_acc, x_acc};
      m_tuser <= updated;
    end
  end

  // CORDIC runs on the midpoint heading.
  assign cor_ang = theta_acc + hth;

  odo_div #(
    .NW(ODO_NW),
    .DW(ODO_DW)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .go  (cmd.div_go),
    .n   (n_r),
    .d   (d_r),
    .done(div_done),
    .q   (div_q)
  );

  odo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.cor_go),
    .ang  (cor_ang),
    .done (cor_done),
    .cos_o(cor_cos),
    .sin_o(cor_sin)
  );

  always_comb begin
    status.mode      = mode_r;
    status.primed    = primed;
    status.intv_zero = (intv_r == '0);
    status.mac_last  = mac_last;
    status.div_done  = div_done;
    status.cor_done  = cor_done;
  end

endmodule

// ----- hdl/odo_ctrl.sv -----
// Controller: sequences the datapath units for each request and owns the handshakes.
module odo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  odo_pkg::status_t status,
  output odo_pkg::cmd_t    cmd
);
  import odo_pkg::*;

  state_t state;
  state_t state_next;
  logic   first;

  // State register; first marks the opening cycle of a state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b1;
    end else begin
      state <= state_next;
      first <= (state_next != state);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        priority if (status.mode) state_next = S_RESET_POSE;
        else if (!status.primed) state_next = S_PRIME;
        else state_next = S_CALC;
      end
      S_RESET_POSE: state_next = S_DONE;
      S_PRIME: state_next = S_DONE;
      S_CALC: state_next = S_MUL_DEN;
      S_MUL_DEN: if (status.mac_last) state_next = S_MUL_ANG;
      S_MUL_ANG: if (status.mac_last) state_next = S_DIV_ANG;
      S_DIV_ANG: if (status.div_done) state_next = S_LD_C;
      S_LD_C: state_next = S_DIV_C;
      S_DIV_C: if (status.div_done) state_next = S_CORDIC;
      S_CORDIC: if (status.cor_done) state_next = S_MUL_X;
      S_MUL_X: state_next = S_ADD_X;
      S_ADD_X: state_next = S_ADD_Y;
      S_ADD_Y: state_next = status.intv_zero ? S_COMMIT : S_MUL_VLN;
      S_MUL_VLN: if (status.mac_last) state_next = S_MUL_VLD;
      S_MUL_VLD: if (status.mac_last) state_next = S_DIV_VL;
      S_DIV_VL: if (status.div_done) state_next = S_MUL_VAN;
      S_MUL_VAN: if (status.mac_last) state_next = S_MUL_VAD;
      S_MUL_VAD: if (status.mac_last) state_next = S_DIV_VA;
      S_DIV_VA: if (status.div_done) state_next = S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_DONE: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = s_tvalid;
      S_DISPATCH: ;
      S_RESET_POSE: cmd.clr_pose = 1'b1;
      S_PRIME: cmd.prime = 1'b1;
      S_CALC: cmd.calc = 1'b1;
      S_MUL_DEN: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_DEN;
      end
      S_MUL_ANG: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_ANG;
      end
      S_DIV_ANG: begin
        cmd.div_go = first;
        cmd.cap    = status.div_done ? CAP_ANG : CAP_NONE;
      end
      S_LD_C: cmd.ld_cdiv = 1'b1;
      S_DIV_C: begin
        cmd.div_go = first;
        cmd.cap    = status.div_done ? CAP_C : CAP_NONE;
      end
      S_CORDIC: cmd.cor_go = first;
      S_MUL_X: cmd.mul_x = 1'b1;
      S_ADD_X: begin
        cmd.add_x = 1'b1;
        cmd.mul_y = 1'b1;
      end
      S_ADD_Y: cmd.add_y = 1'b1;
      S_MUL_VLN: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_VLN;
      end
      S_MUL_VLD: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_VLD;
      end
      S_DIV_VL: begin
        cmd.div_go = first;
        cmd.cap    = status.div_done ? CAP_VL : CAP_NONE;
      end
      S_MUL_VAN: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_VAN;
      end
      S_MUL_VAD: begin
        cmd.mac_go  = first;
        cmd.mac_sel = MS_VAD;
      end
      S_DIV_VA: begin
        cmd.div_go = first;
        cmd.cap    = status.div_done ? CAP_VA : CAP_NONE;
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_DONE: cmd.out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  // Result valid: set on load, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // A finished product only appears while a multiply state waits for it.
  a_mac_state: assert property (@(posedge clk) disable iff (rst)
    status.mac_last |-> (state == S_MUL_DEN || state == S_MUL_ANG ||
      state == S_MUL_VLN || state == S_MUL_VLD || state == S_MUL_VAN ||
      state == S_MUL_VAD))
    else $error("multiply finished outside a multiply state");

  // A quotient only appears while a divide state waits for it.
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV_ANG || state == S_DIV_C ||
      state == S_DIV_VL || state == S_DIV_VA))
    else $error("division finished outside a divide state");

  // The rotation only finishes while the controller waits for it.
  a_cor_state: assert property (@(posedge clk) disable iff (rst)
    status.cor_done |-> state == S_CORDIC)
    else $error("rotation finished outside its state");

  // A loaded result is offered on the next cycle.
  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not offered");

endmodule

// ----- hdl/diff_drive_odometry.sv -----
// Differential-drive odometry, top level: controller and datapath.
// A pose update runs the multiply, divide and CORDIC steps in turn; with a zero interval the
// velocity steps are skipped. A pose reset or priming request needs no arithmetic.
// One request is worked at a time; the next is taken once the result is in the output
// register. The bit-serial divider is used up to four times per pose update.
// Synchronous reset restores the default registers and clears pose, velocities and priming.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = odo_pkg::ODO_CORDIC_STEPS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // left_count [31:0], right_count [63:32], interval_us [87:64]
  input  logic [odo_pkg::ODO_IN_W-1:0]   s_tdata,
  // mode
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pos_x [31:0], pos_y [63:32], heading [95:64], lin_vel [127:96], ang_vel [159:128]
  output logic [odo_pkg::ODO_OUT_W-1:0]  m_tdata,
  // pose_updated
  output logic                           m_tuser,
  input  logic                           cfg_we,
  input  logic [odo_pkg::ODO_CFG_IW-1:0] cfg_index,
  input  logic [odo_pkg::ODO_CFG_DW-1:0] cfg_data
);
  import odo_pkg::*;

  cmd_t    cmd;
  status_t status;

  odo_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  odo_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
